[hw/rtl/hrme_pkg.sv]
`default_nettype none
package hrme_pkg;

	// Report identifiers
	localparam logic [7:0] ID_TRANSLATION = 8'd1;
	localparam logic [7:0] ID_ROTATION    = 8'd2;
	localparam logic [7:0] ID_BUTTONS     = 8'd3;

	// Event kinds
	localparam logic [1:0] KIND_BUTTON = 2'd0;
	localparam logic [1:0] KIND_MOTION = 2'd1;
	localparam logic [1:0] KIND_FLUSH  = 2'd2;

	localparam int BUTTON_BITS = 24;
	localparam int AXIS_W      = 16;
	localparam int LEN_W       = 11;
	localparam int IDX_W       = 5;
	localparam int WORDS       = 6;

	// Controller to datapath
	typedef struct packed {
		logic load;   // capture an accepted report
		logic step;   // examine the next index
		logic flush;  // emit the closing event
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rpt_ok;     // report produces a run of events
		logic scan_last;  // current index is the last one of the scan
		logic slot_free;  // result register can take an event this cycle
	} sts_t;

endpackage
`default_nettype wire

[hw/rtl/hrme_ctrl.sv]
`default_nettype none
module hrme_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire hrme_pkg::sts_t sts,
	output hrme_pkg::cmd_t     cmd
);
	import hrme_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH
	} state_t;

	state_t state_q;

	// Take a report only between runs
	assign in_ready = (state_q == S_IDLE);

	// Issue commands from state and status
	always_comb begin
		cmd.load  = (state_q == S_IDLE) && in_valid && sts.rpt_ok;
		cmd.step  = (state_q == S_SCAN) && sts.slot_free;
		cmd.flush = (state_q == S_FLUSH) && sts.slot_free;
	end

	// Advance through the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cmd.step && sts.scan_last) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (cmd.flush) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/hrme_dp.sv]
`default_nettype none
module hrme_dp #(
	parameter int NUM_AXES = 6
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [7:0]                          report_id,
	input  wire logic [hrme_pkg::LEN_W-1:0]          report_len,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word0,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word1,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word2,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word3,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word4,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word5,
	input  wire hrme_pkg::cmd_t                      cmd,
	output hrme_pkg::sts_t                           sts,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               event_kind,
	output logic [hrme_pkg::IDX_W-1:0]               event_index,
	output logic signed [hrme_pkg::AXIS_W-1:0]       event_value,
	output logic                                     last_of_run
);
	import hrme_pkg::*;

	localparam logic [IDX_W-1:0] LAST_AXIS = IDX_W'(NUM_AXES - 1);
	localparam logic [IDX_W-1:0] LAST_BTN  = IDX_W'(BUTTON_BITS - 1);

	logic [AXIS_W-1:0]      words   [WORDS];
	logic [AXIS_W-1:0]      nxt     [NUM_AXES];
	logic [AXIS_W-1:0]      held_axes_q [NUM_AXES];
	logic [AXIS_W-1:0]      axval_q [NUM_AXES];
	logic [BUTTON_BITS-1:0] held_buttons_q;
	logic [BUTTON_BITS-1:0] btnval_q;
	logic [BUTTON_BITS-1:0] diff_q;
	logic [BUTTON_BITS-1:0] cur_btn;
	logic [BUTTON_BITS-1:0] axis_diff;
	logic                   mode_btn_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   out_valid_q;
	logic                   is_btn;

	assign words[0] = word0;
	assign words[1] = word1;
	assign words[2] = word2;
	assign words[3] = word3;
	assign words[4] = word4;
	assign words[5] = word5;

	assign is_btn  = (report_id == ID_BUTTONS);
	assign cur_btn = {word1[7:0], word0};

	// Form the candidate axis values of the incoming report
	always_comb begin
		axis_diff = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			nxt[i] = held_axes_q[i];
			if (report_id == ID_TRANSLATION) begin
				if (report_len > LEN_W'(2 * (i + 1))) begin
					nxt[i] = words[i];
				end
			end else if (report_id == ID_ROTATION && i >= 3) begin
				nxt[i] = words[i - 3];
			end
			axis_diff[i] = (nxt[i] != held_axes_q[i]);
		end
	end

	// Report status toward the controller
	always_comb begin
		sts.rpt_ok    = (report_len != '0) && (report_id == ID_TRANSLATION ||
		                report_id == ID_ROTATION || report_id == ID_BUTTONS);
		sts.scan_last = (idx_q == (mode_btn_q ? LAST_BTN : LAST_AXIS));
		sts.slot_free = !out_valid_q || out_ready;
	end

	// Held state: commit the new report at load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_buttons_q <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				held_axes_q[i] <= '0;
			end
		end else if (cmd.load) begin
			if (is_btn) begin
				held_buttons_q <= cur_btn;
			end else begin
				for (int i = 0; i < NUM_AXES; i++) begin
					held_axes_q[i] <= nxt[i];
				end
			end
		end
	end

	// Scan registers: load the change vector, then shift one index per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			mode_btn_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q      <= '0;
			mode_btn_q <= is_btn;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q   <= is_btn ? (held_buttons_q ^ cur_btn) : axis_diff;
			btnval_q <= cur_btn;
			for (int i = 0; i < NUM_AXES; i++) begin
				axval_q[i] <= nxt[i];
			end
		end else if (cmd.step) begin
			diff_q   <= diff_q >> 1;
			btnval_q <= btnval_q >> 1;
			for (int i = 0; i < NUM_AXES - 1; i++) begin
				axval_q[i] <= axval_q[i + 1];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.step && diff_q[0]) || cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			event_kind  <= KIND_FLUSH;
			event_index <= '0;
			event_value <= '0;
			last_of_run <= 1'b1;
		end else if (cmd.step && diff_q[0]) begin
			event_kind  <= mode_btn_q ? KIND_BUTTON : KIND_MOTION;
			event_index <= idx_q;
			event_value <= mode_btn_q ? {{(AXIS_W-1){1'b0}}, btnval_q[0]} : axval_q[0];
			last_of_run <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[hw/rtl/hid_report_to_motion_events.sv]
// Operation: after a report is accepted, the block steps through its indices in
// order (each of the 24 button bits, or each of the NUM_AXES axes) and offers an
// event for each index whose value changed, then offers a flush event; a stalled
// output holds the scan. A report with zero length or an unknown identifier is
// accepted and produces no events. A new report is taken only once the flush
// event has been issued.
// Reset: arst_n clears held buttons, held axes and all control state.
`default_nettype none
module hid_report_to_motion_events #(
	parameter int NUM_AXES = 6
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [7:0]                          report_id,
	input  wire logic [hrme_pkg::LEN_W-1:0]          report_len,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word0,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word1,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word2,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word3,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word4,
	input  wire logic [hrme_pkg::AXIS_W-1:0]         word5,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               event_kind,
	output logic [hrme_pkg::IDX_W-1:0]               event_index,
	output logic signed [hrme_pkg::AXIS_W-1:0]       event_value,
	output logic                                     last_of_run
);
	import hrme_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hrme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hrme_dp #(
		.NUM_AXES (NUM_AXES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.report_id   (report_id),
		.report_len  (report_len),
		.word0       (word0),
		.word1       (word1),
		.word2       (word2),
		.word3       (word3),
		.word4       (word4),
		.word5       (word5),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_kind  (event_kind),
		.event_index (event_index),
		.event_value (event_value),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire
